### sv/pending_request_timeout_table_top_defines.svh
// Assertion macros shared by the pending request table checker.
`ifndef PENDING_REQUEST_TIMEOUT_TABLE_TOP_DEFINES_SVH
`define PENDING_REQUEST_TIMEOUT_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PRTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/prtt_pkg.sv
// Shared codes and widths for the pending request timeout table.
package prtt_pkg;

  localparam int unsigned TYPE_W = 2;
  localparam int unsigned KEY_W  = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TMO_W  = 16;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned OCC_W  = 5;

  // request types
  localparam logic [TYPE_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_RESP  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_TICK  = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_FLUSH = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MATCH   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOMATCH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd5;

  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd2;

endpackage

### sv/pending_request_timeout_table_top.sv
// Add: S_ADD writes the entry unless full and loads the result. Response, tick, flush:
// S_IDLE issues the first read, then S_CMP scans the entries through the single compare
// unit, S_MOV does each removal (swap read of the last entry) and S_FIN loads the result;
// a matched response gives its result from S_MOV, an empty table goes straight to S_FIN.
// One request at a time; in_stall_o is high until the request's last result is loaded.
// Async active-low reset empties the table and sets timeout_ticks to 2; storage not cleared.
module pending_request_timeout_table_top
  import prtt_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [TYPE_W-1:0]   req_type_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [TIME_W-1:0]   now_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [KIND_W-1:0]   kind_o,
  output logic [KEY_W-1:0]    entry_key_o,
  output logic [OCC_W-1:0]    occupancy_o,
  output logic                last_o,
  // timeout_ticks register
  input  logic                cfg_we_i,
  input  logic [TMO_W-1:0]    cfg_wdata_i
);

  // Index and count widths; the count must hold DEPTH itself.
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_ADD  = 3'd1;  // write new entry, report
  localparam logic [2:0] S_CMP  = 3'd2;  // compare entry ix, read data valid
  localparam logic [2:0] S_MOV  = 3'd3;  // last entry read back, move it into ix
  localparam logic [2:0] S_FIN  = 3'd4;  // final result of a scan

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [IW-1:0]       ix_q, ix_d;
  logic [TMO_W-1:0]    timeout_q;
  logic [TYPE_W-1:0]   type_q;
  logic [KEY_W-1:0]    key_q;
  logic [TIME_W-1:0]   now_q;
  logic [KEY_W-1:0]    hit_key_q, hit_key_d;
  // Pending expiry: held back until we know whether it is the last one.
  logic                pend_q, pend_d;
  logic [KEY_W-1:0]    pend_key_q, pend_key_d;

  // Entry storage, one registered read port and one write port.
  logic [KEY_W-1:0]    id_mem [DEPTH];
  logic [TIME_W-1:0]   dl_mem [DEPTH];
  logic [KEY_W-1:0]    rd_id_q;
  logic [TIME_W-1:0]   rd_dl_q;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [KEY_W-1:0]    wr_id;
  logic [TIME_W-1:0]   wr_dl;

  // Result register
  logic                out_valid_q;
  logic [KIND_W-1:0]   kind_q;
  logic [KEY_W-1:0]    entry_key_q;
  logic [OCC_W-1:0]    occ_q;
  logic                last_q;

  logic                emit;
  logic [KIND_W-1:0]   emit_kind;
  logic [KEY_W-1:0]    emit_key;
  logic [CW-1:0]       emit_occ;
  logic                emit_last;

  logic                out_free;
  logic                in_acc;
  logic                full;
  logic                hit;
  logic [TIME_W:0]     dl_sum;
  logic [TIME_W-1:0]   dl_new;
  logic [IW-1:0]       last_ix;
  logic                mov_go;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q == CW'(DEPTH));
  assign last_ix    = IW'(count_q - CW'(1));

  // Deadline adder with saturation at the top of the time range.
  assign dl_sum = {1'b0, now_q} + {{(TIME_W + 1 - TMO_W){1'b0}}, timeout_q};
  assign dl_new = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];

  // The one compare unit: id match (response), strict deadline compare (tick), always (flush).
  always_comb begin
    case (type_q)
      REQ_RESP:  hit = (rd_id_q == key_q);
      REQ_TICK:  hit = (rd_dl_q < now_q);
      REQ_FLUSH: hit = 1'b1;
      default:   hit = 1'b0;
    endcase
  end

  // A response move only needs the output; a tick or flush move flushes the pending expiry first.
  assign mov_go = (type_q == REQ_RESP) ? out_free : (!pend_q || out_free);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ix_d       = ix_q;
    hit_key_d  = hit_key_q;
    pend_d     = pend_q;
    pend_key_d = pend_key_q;
    rd_en      = 1'b0;
    rd_addr    = ix_q;
    wr_en      = 1'b0;
    wr_addr    = ix_q;
    wr_id      = rd_id_q;
    wr_dl      = rd_dl_q;
    emit       = 1'b0;
    emit_kind  = KIND_NONE;
    emit_key   = '0;
    emit_occ   = count_q;
    emit_last  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (req_type_i == REQ_ADD) begin
            state_d = S_ADD;
          end else if (count_q == '0) begin
            state_d = S_FIN;
          end else begin
            // scan starts at the highest occupied index
            rd_en   = 1'b1;
            rd_addr = last_ix;
            ix_d    = last_ix;
            state_d = S_CMP;
          end
        end
      end

      S_ADD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          state_d   = S_IDLE;
          if (full) begin
            emit_kind = KIND_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = IW'(count_q);
            wr_id     = key_q;
            wr_dl     = dl_new;
            count_d   = count_q + CW'(1);
            emit_kind = KIND_ADDED;
            emit_key  = key_q;
            emit_occ  = count_q + CW'(1);
          end
        end
      end

      S_CMP: begin
        if (hit) begin
          // fetch the last entry to fill the hole
          hit_key_d = rd_id_q;
          rd_en     = 1'b1;
          rd_addr   = last_ix;
          state_d   = S_MOV;
        end else if (ix_q == '0) begin
          state_d = S_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ix_q - IW'(1);
          ix_d    = ix_q - IW'(1);
        end
      end

      S_MOV: begin
        if (mov_go) begin
          wr_en   = 1'b1;
          count_d = count_q - CW'(1);
          if (type_q == REQ_RESP) begin
            emit      = 1'b1;
            emit_kind = KIND_MATCH;
            emit_key  = key_q;
            emit_occ  = count_q - CW'(1);
            emit_last = 1'b1;
            state_d   = S_IDLE;
          end else begin
            if (pend_q) begin
              emit      = 1'b1;
              emit_kind = KIND_EXPIRED;
              emit_key  = pend_key_q;
            end
            pend_d     = 1'b1;
            pend_key_d = hit_key_q;
            if (ix_q == '0) begin
              state_d = S_FIN;
            end else begin
              rd_en   = 1'b1;
              rd_addr = ix_q - IW'(1);
              ix_d    = ix_q - IW'(1);
              state_d = S_CMP;
            end
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          pend_d    = 1'b0;
          state_d   = S_IDLE;
          if (type_q == REQ_RESP) begin
            emit_kind = KIND_NOMATCH;
          end else if (pend_q) begin
            emit_kind = KIND_EXPIRED;
            emit_key  = pend_key_q;
          end else begin
            emit_kind = KIND_NONE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      timeout_q   <= TIMEOUT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ix_q       <= ix_d;
    hit_key_q  <= hit_key_d;
    pend_key_q <= pend_key_d;
    if (in_acc) begin
      type_q <= req_type_i;
      key_q  <= key_i;
      now_q  <= now_i;
    end
    if (emit) begin
      kind_q      <= emit_kind;
      entry_key_q <= emit_key;
      occ_q       <= OCC_W'(emit_occ);
      last_q      <= emit_last;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_mem[wr_addr] <= wr_id;
      dl_mem[wr_addr] <= wr_dl;
    end
    if (rd_en) begin
      rd_id_q <= id_mem[rd_addr];
      rd_dl_q <= dl_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign entry_key_o = entry_key_q;
  assign occupancy_o = occ_q;
  assign last_o      = last_q;

endmodule

### sv/prtt_checker.sv
// Port-level checker for the pending request table, bound to the top level.
`include "pending_request_timeout_table_top_defines.svh"

module prtt_checker
  import prtt_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [KIND_W-1:0] kind_o,
  input logic [KEY_W-1:0]  entry_key_o,
  input logic [OCC_W-1:0]  occupancy_o,
  input logic              last_o
);

  localparam logic [OCC_W-1:0] OccMax = (DEPTH > 31) ? OCC_W'(31) : OCC_W'(DEPTH);

  // Kinds that never carry an id.
  logic zero_key_kind;
  assign zero_key_kind = (kind_o == KIND_FULL) || (kind_o == KIND_NOMATCH) ||
                         (kind_o == KIND_NONE);

  // An accepted request keeps the block busy in the following cycle.
  `PRTT_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o, "request not held")

  // A stalled result stays offered.
  `PRTT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")

  `PRTT_ASSERT_NOW(a_occ_range, out_valid_o, occupancy_o <= OccMax, "occupancy beyond depth")

  // Only expiries can be followed by more results of the same request.
  `PRTT_ASSERT_NOW(a_single_last, out_valid_o && kind_o != KIND_EXPIRED, last_o, "last missing")

  `PRTT_ASSERT_NOW(a_zero_key, out_valid_o && zero_key_kind, entry_key_o == '0, "key not zero")

endmodule

bind pending_request_timeout_table_top prtt_checker #(.DEPTH(DEPTH)) u_prtt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .entry_key_o (entry_key_o),
  .occupancy_o (occupancy_o),
  .last_o      (last_o)
);

### verif/testbench.sv
// Self-checking testbench for the pending request timeout table: directed and random requests.
module testbench;
  import prtt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  // Watchdog limit in time units, chosen with a wide margin.
  localparam int unsigned RUN_LIMIT   = 4_000_000;
  // Meant to cover a full scan with every entry hit.
  localparam int unsigned TAIL_CYCLES = 40;

  // One result as the table reports it.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  entry_key;
    logic [OCC_W-1:0]  occupancy;
    logic              last;
  } table_outcome_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [TYPE_W-1:0] req_type_i  = REQ_ADD;
  logic [KEY_W-1:0]  key_i       = '0;
  logic [TIME_W-1:0] now_i       = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [KIND_W-1:0] kind_o;
  logic [KEY_W-1:0]  entry_key_o;
  logic [OCC_W-1:0]  occupancy_o;
  logic              last_o;
  logic              cfg_we_i    = 1'b0;
  logic [TMO_W-1:0]  cfg_wdata_i = TIMEOUT_RST;

  // Shadow copy of the table: ids, deadlines, fill level and the timeout register.
  logic [KEY_W-1:0]  pend_id       [TABLE_DEPTH];
  logic [TIME_W-1:0] pend_deadline [TABLE_DEPTH];
  int unsigned       pend_count    = 0;
  logic [TMO_W-1:0]  tmo_ticks     = TIMEOUT_RST;

  // Results predicted but not yet seen on the result channel, oldest first.
  table_outcome_t    awaited_outcomes [$];
  int unsigned       fault_count = 0;
  // When set, neither side inserts idle cycles.
  bit                steady_flow = 1'b0;

  pending_request_timeout_table_top #(
    .DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .now_i       (now_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .entry_key_o (entry_key_o),
    .occupancy_o (occupancy_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Table prediction
  // ---------------------------------------------------------------------------

  // Queue one result; occupancy is the fill level after the action just taken.
  function automatic void post_outcome(input logic [KIND_W-1:0] kind,
                                       input logic [KEY_W-1:0] id);
    awaited_outcomes.push_back({kind, id, OCC_W'(pend_count), 1'b0});
  endfunction

  // Swap-remove: the top entry moves into the freed slot.
  function automatic void drop_entry(input int unsigned ix);
    int unsigned top;
    top = pend_count - 1;
    pend_id[ix]       = pend_id[top];
    pend_deadline[ix] = pend_deadline[top];
    pend_count        = top;
  endfunction

  function automatic void track_table_request(input logic [TYPE_W-1:0] rtype,
                                              input logic [KEY_W-1:0]  rkey,
                                              input logic [TIME_W-1:0] rnow);
    logic [TIME_W:0]  sum;
    logic [KEY_W-1:0] gone;
    int unsigned      produced;
    bit               hit;
    produced = 0;
    hit      = 1'b0;
    case (rtype)
      REQ_ADD: begin
        if (pend_count >= TABLE_DEPTH) begin
          post_outcome(KIND_FULL, '0);
        end else begin
          // deadline saturates instead of wrapping
          sum = {1'b0, rnow} + (TIME_W + 1)'(tmo_ticks);
          pend_id[pend_count]       = rkey;
          pend_deadline[pend_count] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
          pend_count++;
          post_outcome(KIND_ADDED, rkey);
        end
      end
      REQ_RESP: begin
        // highest index wins when an id is held more than once
        for (int i = pend_count; i > 0; i--) begin
          if (!hit && pend_id[i-1] == rkey) begin
            drop_entry(i - 1);
            post_outcome(KIND_MATCH, rkey);
            hit = 1'b1;
          end
        end
        if (!hit) post_outcome(KIND_NOMATCH, '0);
      end
      default: begin
        // tick expires deadlines strictly below now; flush expires everything
        for (int i = pend_count; i > 0; i--) begin
          if (rtype == REQ_FLUSH || pend_deadline[i-1] < rnow) begin
            gone = pend_id[i-1];
            drop_entry(i - 1);
            post_outcome(KIND_EXPIRED, gone);
            produced++;
          end
        end
        if (produced == 0) post_outcome(KIND_NONE, '0);
      end
    endcase
    awaited_outcomes[awaited_outcomes.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Drive one request after a random gap and hold it until the table takes it.
  task automatic issue_request(input logic [TYPE_W-1:0] rtype,
                               input logic [KEY_W-1:0]  rkey,
                               input logic [TIME_W-1:0] rnow);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rtype;
    key_i      <= rkey;
    now_i      <= rnow;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    track_table_request(rtype, rkey, rnow);
  endtask

  // Stop sending and wait for every outstanding result; each request yields at
  // least one result, so an empty queue means the table is idle.
  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_outcomes.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [TMO_W-1:0] value);
    quiesce();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tmo_ticks    = value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fault_count++;
    end
  endfunction

  // Random stall before each result, then compare it with the oldest prediction.
  initial begin : result_sink
    int unsigned    hold;
    table_outcome_t want;
    forever begin
      @(negedge clk_i);
      hold = steady_flow ? 0 : $urandom_range(0, 4);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (awaited_outcomes.size() == 0) begin
        $error("unexpected result: kind %0h key %0h", kind_o, entry_key_o);
        fault_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("entry_key", 32'(want.entry_key), 32'(entry_key_o));
        check_field("occupancy", 32'(want.occupancy), 32'(occupancy_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Response, tick and flush against an empty table.
  task automatic test_empty_table();
    issue_request(REQ_RESP, 8'h5A, 32'h0);
    issue_request(REQ_TICK, 8'h00, 32'hFFFF_FFFF);
    issue_request(REQ_FLUSH, 8'hFF, 32'h0);
  endtask

  // Reset timeout of 2: deadline equal to now survives, one past it expires,
  // and an add at the top of time saturates.
  task automatic test_deadline_edges();
    issue_request(REQ_ADD, 8'h00, 32'd100);
    issue_request(REQ_ADD, 8'hFF, 32'd100);
    issue_request(REQ_ADD, 8'hA5, 32'hFFFF_FFFF);
    issue_request(REQ_TICK, 8'h00, 32'd102);
    issue_request(REQ_TICK, 8'h00, 32'd103);
    issue_request(REQ_RESP, 8'h11, 32'h0);
  endtask

  // Fill to the top with repeated ids, overflow once, match a repeated id,
  // then flush everything from the top down.
  task automatic test_full_table();
    for (int k = 0; k < TABLE_DEPTH - 1; k++)
      issue_request(REQ_ADD, 8'h40 + KEY_W'(k % 6), 32'd1000 + k);
    issue_request(REQ_ADD, 8'h7E, 32'd2000);
    issue_request(REQ_RESP, 8'h41, 32'h0);
    issue_request(REQ_FLUSH, 8'h00, 32'hFFFF_FFFF);
  endtask

  // Mostly coherent traffic: a running clock, ids drawn from a small pool, at random or
  // from the table itself, with some fully random requests mixed in.
  task automatic test_random_traffic(input int unsigned items, input logic [TMO_W-1:0] tmo,
                                     input bit steady_half);
    logic [TIME_W-1:0] clock_ticks;
    logic [KEY_W-1:0]  id;
    int unsigned       step_max;
    int unsigned       pick;
    write_timeout(tmo);
    // now and then start close to the top of time to hit deadline saturation
    if ($urandom_range(0, 3) == 0)
      clock_ticks = 32'hFFFF_FFFF - $urandom_range(0, 3 * tmo + 64);
    else
      clock_ticks = $urandom;
    step_max = tmo / 4 + 2;
    for (int n = 0; n < items; n++) begin
      steady_flow = steady_half && (n < items / 2);
      // sender holds off until every result is back
      if (n > 0 && $urandom_range(0, 24) == 0) quiesce();
      clock_ticks += $urandom_range(0, step_max);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 0)
        id = 8'hC0 + KEY_W'($urandom_range(0, 7));
      else
        id = KEY_W'($urandom);
      if (pick < 10) begin
        issue_request(TYPE_W'($urandom_range(0, 3)), KEY_W'($urandom), $urandom);
      end else if (pick < 50) begin
        issue_request(REQ_ADD, id, clock_ticks);
      end else if (pick < 75) begin
        if (pend_count > 0 && $urandom_range(0, 3) != 0)
          id = pend_id[$urandom_range(0, pend_count - 1)];
        issue_request(REQ_RESP, id, clock_ticks);
      end else if (pick < 95) begin
        issue_request(REQ_TICK, id, clock_ticks);
      end else begin
        issue_request(REQ_FLUSH, id, clock_ticks);
      end
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_table();
    test_deadline_edges();
    test_full_table();
    // timeout extremes, one arbitrary value with a stretch of back-to-back
    // traffic, and a short one
    test_random_traffic(46, 16'd0, 1'b0);
    test_random_traffic(46, 16'hFFFF, 1'b0);
    test_random_traffic(46, TMO_W'($urandom_range(1, 16'hFFFE)), 1'b1);
    test_random_traffic(46, 16'd5, 1'b0);
    quiesce();
    // let any stray result show up
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (awaited_outcomes.size() != 0) begin
      $error("%0d results never arrived", awaited_outcomes.size());
      fault_count++;
    end
    if (fault_count == 0)
      $display("pending_request_timeout_table_top verification clean");
    else
      $display("pending_request_timeout_table_top verification failed");
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("pending_request_timeout_table_top verification failed");
    $finish;
  end

endmodule
